### hw/rtl/fda_pkg.sv
// fda_pkg: shared types and constants for the fixed-point to decimal ASCII converter.
// Used by fda_front, fda_queue, fda_back and fixed_to_decimal_ascii_top.
`timescale 1ns / 1ps
`default_nettype none
package fda_pkg;

  localparam int INT_DIGITS = 10;
  localparam int INT_W      = 31;
  localparam int FRAC_W     = 32;

  localparam logic [5:0]  CHAR_ZERO   = 6'd48;
  localparam logic [5:0]  CHAR_POINT  = 6'd46;
  localparam logic [3:0]  MAX_FRAC    = 4'd9;
  localparam logic [3:0]  FRAC_RESET  = 4'd6;
  // floor(x / 10) == (x * DIV10_MAGIC) >> DIV10_SHIFT for any 32-bit x
  localparam logic [31:0] DIV10_MAGIC = 32'hCCCC_CCCD;
  localparam int          DIV10_SHIFT = 35;

  typedef logic [3:0] digit_t;
  // index 0 holds the most significant digit once conversion ends
  typedef digit_t [INT_DIGITS-1:0] digit_vec_t;

  typedef struct packed {
    digit_vec_t          digits;
    logic [3:0]          int_count;
    logic [FRAC_W-1:0]   frac;
    logic [3:0]          frac_count;
  } fda_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fda_qstat_t;

  typedef enum logic [1:0] {
    FS_IDLE,
    FS_CONV,
    FS_PUSH
  } front_state_t;

  typedef enum logic [1:0] {
    BS_IDLE,
    BS_INT,
    BS_POINT,
    BS_FRAC
  } back_state_t;

endpackage
`default_nettype wire

### hw/rtl/fda_front.sv
// fda_front: takes one number, splits integer and fraction, and converts the
// integer part to decimal digits one per cycle. Depends on fda_pkg.
`timescale 1ns / 1ps
`default_nettype none
module fda_front (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   start,
  output logic                        busy,
  input  wire logic [62:0]            in_fixed_value,
  input  wire logic [3:0]             frac_digits,
  input  wire fda_pkg::fda_qstat_t    qstat,
  output logic                        push,
  output fda_pkg::fda_entry_t         push_entry
);
  import fda_pkg::*;

  front_state_t        state_r, state_nxt;
  logic [INT_W-1:0]    x_r, x_nxt;
  digit_vec_t          digits_r, digits_nxt;
  logic [3:0]          cnt_r, cnt_nxt;
  logic [FRAC_W-1:0]   frac_r;
  logic [3:0]          fcnt_r;
  logic                load, step;

  logic [62:0]         prod;
  logic [INT_W-1:0]    quot;
  logic [INT_W-1:0]    quot10;
  logic [INT_W-1:0]    diff;
  digit_t              rem;

  // divide by ten through the reciprocal
  assign prod   = 63'(x_r) * 63'(DIV10_MAGIC);
  assign quot   = INT_W'(prod[62:DIV10_SHIFT]);
  assign quot10 = (quot << 3) + (quot << 1);
  assign diff   = x_r - quot10;
  assign rem    = diff[3:0];

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      FS_IDLE: if (start) state_nxt = FS_CONV;
      FS_CONV: if (quot == '0) state_nxt = FS_PUSH;
      FS_PUSH: if (!qstat.full) state_nxt = FS_IDLE;
      default: state_nxt = FS_IDLE;
    endcase
  end

  always_comb begin
    busy = 1'b1;
    load = 1'b0;
    step = 1'b0;
    push = 1'b0;
    unique case (state_r)
      FS_IDLE: begin
        busy = 1'b0;
        load = start;
      end
      FS_CONV: step = 1'b1;
      FS_PUSH: push = !qstat.full;
      default: ;
    endcase
  end

  always_comb begin
    x_nxt      = x_r;
    digits_nxt = digits_r;
    cnt_nxt    = cnt_r;
    if (load) begin
      x_nxt   = in_fixed_value[62:32];
      cnt_nxt = 4'd0;
    end else if (step) begin
      x_nxt      = quot;
      digits_nxt = {digits_r[INT_DIGITS-2:0], rem};
      cnt_nxt    = cnt_r + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= FS_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r      <= x_nxt;
    digits_r <= digits_nxt;
    cnt_r    <= cnt_nxt;
    if (load) begin
      frac_r <= in_fixed_value[31:0];
      // saturate the digit count at nine
      fcnt_r <= (frac_digits > MAX_FRAC) ? MAX_FRAC : frac_digits;
    end
  end

  assign push_entry.digits     = digits_r;
  assign push_entry.int_count  = cnt_r;
  assign push_entry.frac       = frac_r;
  assign push_entry.frac_count = fcnt_r;

  a_conv_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == FS_CONV |-> cnt_r < 4'(INT_DIGITS))
    else $error("integer conversion ran past ten digits");

endmodule
`default_nettype wire

### hw/rtl/fda_queue.sv
// fda_queue: short word queue between the converter front and the emitter back.
// Depends on fda_pkg.
`timescale 1ns / 1ps
`default_nettype none
module fda_queue #(
  parameter int DEPTH = 2
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 push,
  input  wire fda_pkg::fda_entry_t  push_entry,
  input  wire logic                 pop,
  output fda_pkg::fda_entry_t       head,
  output fda_pkg::fda_qstat_t       qstat
);
  import fda_pkg::*;

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  fda_entry_t         mem_r [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic               do_push, do_pop;

  assign qstat.full  = (count_r == CNT_W'(DEPTH));
  assign qstat.empty = (count_r == '0);
  assign do_push     = push && !qstat.full;
  assign do_pop      = pop && !qstat.empty;
  assign head        = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    case ({do_push, do_pop})
      2'b10:   count_nxt = count_r + 1'b1;
      2'b01:   count_nxt = count_r - 1'b1;
      default: count_nxt = count_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    push |-> !qstat.full)
    else $error("word pushed into a full queue");

  a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("queue count beyond depth");

endmodule
`default_nettype wire

### hw/rtl/fda_back.sv
// fda_back: emits the decimal text of one queued word, one character per cycle,
// producing fraction digits by repeated multiply by ten. Depends on fda_pkg.
`timescale 1ns / 1ps
`default_nettype none
module fda_back (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire fda_pkg::fda_entry_t  head,
  input  wire fda_pkg::fda_qstat_t  qstat,
  output logic                      pop,
  output logic                      out_strobe,
  output logic [5:0]                out_char_code,
  output logic                      out_last
);
  import fda_pkg::*;

  back_state_t         state_r, state_nxt;
  digit_vec_t          dig_r;
  logic [3:0]          ileft_r;
  logic [FRAC_W-1:0]   frac_r;
  logic [3:0]          fcount_r;
  logic [3:0]          fleft_r;
  logic [FRAC_W+3:0]   frac_x10;

  logic                emit;
  logic [5:0]          code;
  logic                is_last;
  logic                out_strobe_r;
  logic [5:0]          out_char_code_r;
  logic                out_last_r;

  assign frac_x10 = ({4'd0, frac_r} << 3) + ({4'd0, frac_r} << 1);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      BS_IDLE:  if (!qstat.empty) state_nxt = BS_INT;
      BS_INT: begin
        if (ileft_r == 4'd1) state_nxt = (fcount_r != 4'd0) ? BS_POINT : BS_IDLE;
      end
      BS_POINT: state_nxt = BS_FRAC;
      BS_FRAC:  if (fleft_r == 4'd1) state_nxt = BS_IDLE;
      default:  state_nxt = BS_IDLE;
    endcase
  end

  always_comb begin
    pop     = 1'b0;
    emit    = 1'b0;
    code    = CHAR_ZERO;
    is_last = 1'b0;
    unique case (state_r)
      BS_IDLE: pop = !qstat.empty;
      BS_INT: begin
        emit    = 1'b1;
        code    = CHAR_ZERO + {2'b00, dig_r[0]};
        is_last = (ileft_r == 4'd1) && (fcount_r == 4'd0);
      end
      BS_POINT: begin
        emit = 1'b1;
        code = CHAR_POINT;
      end
      BS_FRAC: begin
        emit    = 1'b1;
        code    = CHAR_ZERO + {2'b00, frac_x10[FRAC_W+3:FRAC_W]};
        is_last = (fleft_r == 4'd1);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= BS_IDLE;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      out_strobe_r <= emit;
    end
  end

  always_ff @(posedge clk) begin
    out_char_code_r <= code;
    out_last_r      <= is_last;
    if (pop) begin
      dig_r    <= head.digits;
      ileft_r  <= head.int_count;
      frac_r   <= head.frac;
      fcount_r <= head.frac_count;
      fleft_r  <= head.frac_count;
    end else if (state_r == BS_INT) begin
      // advance to the next lower integer digit
      dig_r   <= {4'd0, dig_r[INT_DIGITS-1:1]};
      ileft_r <= ileft_r - 4'd1;
    end else if (state_r == BS_FRAC) begin
      frac_r  <= frac_x10[FRAC_W-1:0];
      fleft_r <= fleft_r - 4'd1;
    end
  end

  assign out_strobe    = out_strobe_r;
  assign out_char_code = out_char_code_r;
  assign out_last      = out_last_r;

  a_pop_starts_int: assert property (@(posedge clk) disable iff (!rst_n)
    pop |=> state_r == BS_INT)
    else $error("popped word did not start integer emission");

  a_int_has_digits: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == BS_INT |-> ileft_r != 4'd0)
    else $error("integer emission with no digits left");

  a_gap_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe_r && out_last_r |=> !out_strobe_r)
    else $error("character emitted straight after the last one");

endmodule
`default_nettype wire

### hw/rtl/fixed_to_decimal_ascii_top.sv
// Path: with the back idle, the first character of a number with 1 to 10 integer digits
// reaches the ports after the divide-by-ten steps in the front, the push into the queue,
// the pop in the back and the emitting state, whose character is registered on the ports.
// Pace: the front takes a new number only after it has pushed the last; the back pops
// a new word only after its last character, and the slower side sets the pace.
// Reset: frac_digits returns to 6, the queue empties and no character is pending.
// The receiver cannot stall: every strobed character is taken in its cycle.
`timescale 1ns / 1ps
`default_nettype none
module fixed_to_decimal_ascii_top #(
  parameter int QUEUE_DEPTH = 2
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         start,
  output logic              busy,
  input  wire logic [62:0]  in_fixed_value,
  output logic              out_strobe,
  output logic [5:0]        out_char_code,
  output logic              out_last,
  input  wire logic         cfg_valid,
  output logic              cfg_ready,
  input  wire logic [3:0]   cfg_frac_digits
);
  import fda_pkg::*;

  logic [3:0]   frac_digits_r;
  logic         push;
  logic         pop;
  fda_entry_t   push_entry;
  fda_entry_t   head;
  fda_qstat_t   qstat;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frac_digits_r <= FRAC_RESET;
    end else if (cfg_valid && cfg_ready) begin
      frac_digits_r <= cfg_frac_digits;
    end
  end

  fda_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_fixed_value (in_fixed_value),
    .frac_digits    (frac_digits_r),
    .qstat          (qstat),
    .push           (push),
    .push_entry     (push_entry)
  );

  fda_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .qstat      (qstat)
  );

  fda_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .head          (head),
    .qstat         (qstat),
    .pop           (pop),
    .out_strobe    (out_strobe),
    .out_char_code (out_char_code),
    .out_last      (out_last)
  );

endmodule
`default_nettype wire
